// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the prefix trie matcher.
// Depends on nothing; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/ptm_pkg.sv -----
// Package for the prefix trie matcher: constants, action codes, memory control struct.
// Depends on nothing.
`default_nettype none
package ptm_pkg;
   localparam int SYMBOL_W          = 8;
   localparam int RECIP_SHIFT       = 16;
   localparam int PROD_W            = SYMBOL_W + RECIP_SHIFT;
   localparam int NODE_COUNT_DEF    = 256;
   localparam int ALPHABET_SIZE_DEF = 256;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   // Control strobes from the walker to the node memories
   typedef struct packed {
      logic child_rd;
      logic child_wr;
      logic mark_rd;
      logic mark_wr;
      logic mark_val;
   } ptm_mem_ctl_type;
endpackage
`default_nettype wire

// ----- rtl/ptm_sym_mod.sv -----
// Symbol reduction modulo the alphabet size by reciprocal multiply and one correction.
// Depends on ptm_pkg.
`default_nettype none
module ptm_sym_mod #(
   parameter int ALPHABET_SIZE = ptm_pkg::ALPHABET_SIZE_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              load,
   input  wire logic [ptm_pkg::SYMBOL_W-1:0]      sym,
   output logic      [$clog2(ALPHABET_SIZE)-1:0]  residue
);
   localparam int SYM_W = $clog2(ALPHABET_SIZE);
   localparam logic [ptm_pkg::RECIP_SHIFT-1:0] RECIP_V =
      ptm_pkg::RECIP_SHIFT'((2 ** ptm_pkg::RECIP_SHIFT) / ALPHABET_SIZE);
   localparam logic [ptm_pkg::SYMBOL_W:0] ALPHA_V = (ptm_pkg::SYMBOL_W+1)'(ALPHABET_SIZE);

   logic [ptm_pkg::SYMBOL_W-1:0]          sym_ff;
   logic [ptm_pkg::PROD_W-1:0]            prod_ff;
   logic [ptm_pkg::SYMBOL_W-1:0]          quot;
   logic [2*ptm_pkg::SYMBOL_W:0]          quot_alpha;
   logic [ptm_pkg::SYMBOL_W:0]            diff;
   logic [ptm_pkg::SYMBOL_W:0]            fixed;

   // Quotient estimate, registered at accept
   always_ff @(posedge clock) begin
      if (load) begin
         sym_ff  <= sym;
         prod_ff <= {{ptm_pkg::RECIP_SHIFT{1'b0}}, sym} *
                    {{ptm_pkg::SYMBOL_W{1'b0}}, RECIP_V};
      end
   end

   // Estimate is low by at most one: one compare and subtract
   always_comb begin
      quot       = prod_ff[ptm_pkg::PROD_W-1:ptm_pkg::RECIP_SHIFT];
      quot_alpha = {{(ptm_pkg::SYMBOL_W+1){1'b0}}, quot} *
                   {{ptm_pkg::SYMBOL_W{1'b0}}, ALPHA_V};
      diff       = {1'b0, sym_ff} - quot_alpha[ptm_pkg::SYMBOL_W:0];
      fixed      = (diff >= ALPHA_V) ? (diff - ALPHA_V) : diff;
      residue    = fixed[SYM_W-1:0];
   end
endmodule
`default_nettype wire

// ----- rtl/ptm_node_mem.sv -----
// Node memories: child table indexed by {node, symbol} and the end-mark table.
// Depends on ptm_pkg. Single port each, read data registered.
`default_nettype none
module ptm_node_mem #(
   parameter int NODE_COUNT    = ptm_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = ptm_pkg::ALPHABET_SIZE_DEF
) (
   input  wire logic                            clock,
   input  wire ptm_pkg::ptm_mem_ctl_type        ctl,
   input  wire logic [$clog2(NODE_COUNT)+$clog2(ALPHABET_SIZE)-1:0] child_addr,
   input  wire logic [$clog2(NODE_COUNT)-1:0]   child_wdata,
   output logic      [$clog2(NODE_COUNT)-1:0]   child_rdata,
   input  wire logic [$clog2(NODE_COUNT)-1:0]   mark_addr,
   output logic                                 mark_rdata
);
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int SYM_W       = $clog2(ALPHABET_SIZE);
   localparam int CHILD_DEPTH = NODE_COUNT * (2 ** SYM_W);

   logic [NODE_W-1:0] child_mem [CHILD_DEPTH];
   logic              mark_mem  [NODE_COUNT];

   // Child table port
   always_ff @(posedge clock) begin
      if (ctl.child_wr) begin
         child_mem[child_addr] <= child_wdata;
      end
      if (ctl.child_rd) begin
         child_rdata <= child_mem[child_addr];
      end
   end

   // End-mark port
   always_ff @(posedge clock) begin
      if (ctl.mark_wr) begin
         mark_mem[mark_addr] <= ctl.mark_val;
      end
      if (ctl.mark_rd) begin
         mark_rdata <= mark_mem[mark_addr];
      end
   end
endmodule
`default_nettype wire

// ----- rtl/prefix_trie_matcher.sv -----
// Top level of the prefix trie matcher: walker state machine, clearing sweep, result register.
// Depends on ptm_pkg, ptm_sym_mod, ptm_node_mem and assert_macros.svh.
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+---------------------------
//  request   | req_action, req_symbol, req_terminator       | start & !busy
//  response  | rsp_done_action, rsp_matched, rsp_table_full | rsp_valid, one cycle
//
// Each transaction passes through accept (S_IDLE), memory fetch (S_FETCH), and evaluate and
// write back (S_EVAL); busy is high in S_FETCH and S_EVAL. The single-port child memory read
// and its write back at the same address set this sequence.
// A terminator's response strobes in the cycle after its evaluate cycle.
// After reset a clearing sweep writes zero to every child entry (NODE_COUNT * 2**clog2(ALPHABET_SIZE),
// 65536 by default) and end mark, one entry a cycle, with busy high.
// The receiver cannot stall; a response is present for one cycle only.
`default_nettype none
`include "assert_macros.svh"
module prefix_trie_matcher #(
   parameter int NODE_COUNT    = ptm_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = ptm_pkg::ALPHABET_SIZE_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_action,
   input  wire logic [ptm_pkg::SYMBOL_W-1:0]   req_symbol,
   input  wire logic                           req_terminator,
   output logic                                rsp_valid,
   output logic                                rsp_done_action,
   output logic                                rsp_matched,
   output logic                                rsp_table_full
);
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int SYM_W       = $clog2(ALPHABET_SIZE);
   localparam int ADDR_W      = NODE_W + SYM_W;
   localparam int FREE_W      = $clog2(NODE_COUNT + 1);
   localparam int CHILD_DEPTH = NODE_COUNT * (2 ** SYM_W);
   localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(CHILD_DEPTH - 1);
   localparam logic [FREE_W-1:0] FREE_FULL  = FREE_W'(NODE_COUNT);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_FETCH = 4'b0100,
      S_EVAL  = 4'b1000
   } ptm_state_type;

   ptm_state_type             state_ff, state_in;
   logic [ADDR_W-1:0]         clear_ff, clear_in;
   logic [FREE_W-1:0]         next_free_ff, next_free_in;
   logic [NODE_W-1:0]         cursor_ff, cursor_in;
   logic                      prefix_seen_ff, prefix_seen_in;
   logic                      path_dead_ff, path_dead_in;
   logic                      action_ff, action_in;
   logic                      term_ff, term_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_action_ff, rsp_action_in;
   logic                      rsp_matched_ff, rsp_matched_in;
   logic                      rsp_full_ff, rsp_full_in;

   logic                      accept;
   logic [SYM_W-1:0]          residue;
   ptm_pkg::ptm_mem_ctl_type  mem_ctl;
   logic [ADDR_W-1:0]         child_addr;
   logic [NODE_W-1:0]         child_wdata;
   logic [NODE_W-1:0]         child_rdata;
   logic [NODE_W-1:0]         mark_addr;
   logic                      mark_rdata;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   ptm_sym_mod #(
      .ALPHABET_SIZE(ALPHABET_SIZE)
   ) u_sym_mod (
      .clock   (clock),
      .load    (accept),
      .sym     (req_symbol),
      .residue (residue)
   );

   ptm_node_mem #(
      .NODE_COUNT   (NODE_COUNT),
      .ALPHABET_SIZE(ALPHABET_SIZE)
   ) u_node_mem (
      .clock       (clock),
      .ctl         (mem_ctl),
      .child_addr  (child_addr),
      .child_wdata (child_wdata),
      .child_rdata (child_rdata),
      .mark_addr   (mark_addr),
      .mark_rdata  (mark_rdata)
   );

   // Walker: clearing sweep, fetch, evaluate and write back
   always_comb begin
      state_in       = state_ff;
      clear_in       = clear_ff;
      next_free_in   = next_free_ff;
      cursor_in      = cursor_ff;
      prefix_seen_in = prefix_seen_ff;
      path_dead_in   = path_dead_ff;
      action_in      = action_ff;
      term_in        = term_ff;
      rsp_valid_in   = 1'b0;
      rsp_action_in  = rsp_action_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_full_in    = rsp_full_ff;
      mem_ctl        = '0;
      child_addr     = {cursor_ff, residue};
      child_wdata    = next_free_ff[NODE_W-1:0];
      mark_addr      = cursor_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_ctl.child_wr = 1'b1;
            mem_ctl.mark_wr  = 1'b1;
            child_addr       = clear_ff;
            child_wdata      = '0;
            mark_addr        = clear_ff[ADDR_W-1:SYM_W];
            clear_in         = clear_ff + ADDR_W'(1);
            if (clear_ff == CLEAR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               action_in = req_action;
               term_in   = req_terminator;
               state_in  = S_FETCH;
            end
         end
         S_FETCH: begin
            mem_ctl.child_rd = 1'b1;
            mem_ctl.mark_rd  = 1'b1;
            state_in         = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_IDLE;
            if (term_ff) begin
               // End of string: report and return the walk to the root
               rsp_valid_in   = 1'b1;
               rsp_action_in  = action_ff;
               rsp_matched_in = 1'b0;
               rsp_full_in    = 1'b0;
               if (action_ff == ptm_pkg::ACT_INSERT) begin
                  if (path_dead_ff) begin
                     rsp_full_in = 1'b1;
                  end else begin
                     mem_ctl.mark_wr  = 1'b1;
                     mem_ctl.mark_val = 1'b1;
                  end
               end else begin
                  rsp_matched_in = prefix_seen_ff || (!path_dead_ff && mark_rdata);
               end
               cursor_in      = '0;
               prefix_seen_in = 1'b0;
               path_dead_in   = 1'b0;
            end else if (action_ff == ptm_pkg::ACT_INSERT) begin
               // Insert byte: follow or allocate the child, or mark the path dead when the table is full
               if (!path_dead_ff) begin
                  if (child_rdata == '0) begin
                     if (next_free_ff == FREE_FULL) begin
                        path_dead_in = 1'b1;
                     end else begin
                        mem_ctl.child_wr = 1'b1;
                        cursor_in        = next_free_ff[NODE_W-1:0];
                        next_free_in     = next_free_ff + FREE_W'(1);
                     end
                  end else begin
                     cursor_in = child_rdata;
                  end
               end
            end else begin
               // Query byte: stop at an end mark or a missing child
               if (!(path_dead_ff || prefix_seen_ff)) begin
                  if (mark_rdata) begin
                     prefix_seen_in = 1'b1;
                  end else if (child_rdata == '0) begin
                     path_dead_in = 1'b1;
                  end else begin
                     cursor_in = child_rdata;
                  end
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clear_ff       <= '0;
         next_free_ff   <= FREE_W'(1);
         cursor_ff      <= '0;
         prefix_seen_ff <= 1'b0;
         path_dead_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_ff       <= clear_in;
         next_free_ff   <= next_free_in;
         cursor_ff      <= cursor_in;
         prefix_seen_ff <= prefix_seen_in;
         path_dead_ff   <= path_dead_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Transaction and response payload
   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      term_ff        <= term_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_done_action = rsp_action_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_table_full  = rsp_full_ff;

   // Checks
   `ASSERT_ALWAYS(a_rsp_idle, clock, reset, !rsp_valid || !busy, "response while busy")
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "accept without busy")
   `ASSERT_NEXT(a_rsp_after_term, clock, reset, !(state_ff == S_EVAL && term_ff), !rsp_valid, "response without terminator")
   `ASSERT_ALWAYS(a_free_bound, clock, reset, next_free_ff <= FREE_FULL, "free counter overrun")
endmodule
`default_nettype wire
